[sv/aesri_pkg.sv]
package aesri_pkg;

    typedef enum logic [2:0] {
        OP_ENC      = 3'd0,
        OP_ENCLAST  = 3'd1,
        OP_DEC      = 3'd2,
        OP_DECLAST  = 3'd3,
        OP_IMC      = 3'd4,
        OP_KEYGEN   = 3'd5,
        OP_RSVD6    = 3'd6,
        OP_RSVD7    = 3'd7
    } opcode_t;

    localparam int TDATA_IN_W  = 272;
    localparam int TDATA_OUT_W = 128;

    // Payload carried down the pipeline
    typedef struct packed {
        opcode_t      op;
        logic [127:0] data;
        logic [127:0] key;
        logic [7:0]   rcon;
    } stage_t;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    // Forward column mix on one 32-bit column (byte 0 in the low bits)
    function automatic logic [31:0] mix_fwd(input logic [31:0] c);
        logic [7:0] a [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++) a[i] = c[8*i +: 8];
        for (int i = 0; i < 4; i++)
            r[8*i +: 8] = xt(a[i]) ^ xt(a[(i+1)%4]) ^ a[(i+1)%4]
                        ^ a[(i+2)%4] ^ a[(i+3)%4];
        mix_fwd = r;
    endfunction

    // Inverse column mix: coefficients 14, 11, 13, 9
    function automatic logic [31:0] mix_inv(input logic [31:0] c);
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] a  [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++)
        begin
            a[i]  = c[8*i +: 8];
            a2[i] = xt(a[i]);
            a4[i] = xt(a2[i]);
            a8[i] = xt(a4[i]);
        end
        for (int i = 0; i < 4; i++)
            r[8*i +: 8] = (a8[i] ^ a4[i] ^ a2[i])
                        ^ (a8[(i+1)%4] ^ a2[(i+1)%4] ^ a[(i+1)%4])
                        ^ (a8[(i+2)%4] ^ a4[(i+2)%4] ^ a[(i+2)%4])
                        ^ (a8[(i+3)%4] ^ a[(i+3)%4]);
        mix_inv = r;
    endfunction

endpackage

[sv/aesri_sub.sv]
// Stage 1: row shift and byte substitution (keygen words substituted in place)
module aesri_sub (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  aesri_pkg::stage_t  din,
    output logic               vout,
    output aesri_pkg::stage_t  dout
);
    aesri_pkg::stage_t stage_next;
    aesri_pkg::stage_t stage_reg;
    logic              valid_reg;
    logic [7:0]        sr [16];
    logic              inv;

    always_comb
    begin
        stage_next = din;
        inv = (din.op == aesri_pkg::OP_DEC) || (din.op == aesri_pkg::OP_DECLAST);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sr[r + 4*c] = inv ? din.data[8*(r + 4*((c + 4 - r) % 4)) +: 8]
                                  : din.data[8*(r + 4*((c + r) % 4)) +: 8];
        unique case (din.op)
            aesri_pkg::OP_ENC, aesri_pkg::OP_ENCLAST:
                for (int i = 0; i < 16; i++)
                    stage_next.data[8*i +: 8] = aesri_pkg::FWD_BOX[sr[i]];
            aesri_pkg::OP_DEC, aesri_pkg::OP_DECLAST:
                for (int i = 0; i < 16; i++)
                    stage_next.data[8*i +: 8] = aesri_pkg::INV_BOX[sr[i]];
            aesri_pkg::OP_KEYGEN:
                for (int i = 0; i < 4; i++)
                begin
                    stage_next.data[32 + 8*i +: 8] =
                        aesri_pkg::FWD_BOX[din.data[32 + 8*i +: 8]];
                    stage_next.data[96 + 8*i +: 8] =
                        aesri_pkg::FWD_BOX[din.data[96 + 8*i +: 8]];
                end
            default: ;
        endcase
    end

    // Advance on enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign vout = valid_reg;
    assign dout = stage_reg;
endmodule

[sv/aesri_mix.sv]
// Stage 2: column mix (forward or inverse) for the ops that need it
module aesri_mix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  aesri_pkg::stage_t  din,
    output logic               vout,
    output aesri_pkg::stage_t  dout
);
    aesri_pkg::stage_t stage_next;
    aesri_pkg::stage_t stage_reg;
    logic              valid_reg;

    always_comb
    begin
        stage_next = din;
        unique case (din.op)
            aesri_pkg::OP_ENC:
                for (int c = 0; c < 4; c++)
                    stage_next.data[32*c +: 32] = aesri_pkg::mix_fwd(din.data[32*c +: 32]);
            aesri_pkg::OP_DEC, aesri_pkg::OP_IMC:
                for (int c = 0; c < 4; c++)
                    stage_next.data[32*c +: 32] = aesri_pkg::mix_inv(din.data[32*c +: 32]);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign vout = valid_reg;
    assign dout = stage_reg;
endmodule

[sv/aesri_fin.sv]
// Stage 3: key add, keygen assembly, zero for reserved codes
module aesri_fin (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  aesri_pkg::stage_t  din,
    output logic               vout,
    output logic [127:0]       dout
);
    logic [127:0] res_next;
    logic [127:0] res_reg;
    logic         valid_reg;
    logic [31:0]  wa;
    logic [31:0]  wb;

    always_comb
    begin
        wa = din.data[63:32];
        wb = din.data[127:96];
        unique case (din.op)
            aesri_pkg::OP_ENC, aesri_pkg::OP_ENCLAST,
            aesri_pkg::OP_DEC, aesri_pkg::OP_DECLAST:
                res_next = din.data ^ din.key;
            aesri_pkg::OP_IMC:
                res_next = din.data;
            aesri_pkg::OP_KEYGEN:
                res_next = {({wb[7:0], wb[31:8]} ^ {24'd0, din.rcon}), wb,
                            ({wa[7:0], wa[31:8]} ^ {24'd0, din.rcon}), wa};
            default:
                res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign vout = valid_reg;
    assign dout = res_reg;
endmodule

[sv/aes_round_instruction_unit.sv]
// AES round instruction unit: one AES-NI style operation (enc, enclast, dec,
// declast, imc, keygenassist) per transfer, one transfer per cycle sustained
// while the output is not stalled. Substitution, column mix and key add are
// each one register stage, and a transfer passes through them in that order
// before its result is offered on the output. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall
// on the output side holds every stage and drops nothing.
module aes_round_instruction_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0], state_lo[66:3], state_hi[130:67], key_lo[194:131],
    // key_hi[258:195], round_constant[266:259], zero fill to 271
    input  logic [aesri_pkg::TDATA_IN_W-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_lo[63:0], result_hi[127:64]
    output logic [aesri_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    aesri_pkg::stage_t din;
    aesri_pkg::stage_t s1;
    aesri_pkg::stage_t s2;
    logic              v1;
    logic              v2;
    logic              en;

    // Advance all stages when the output slot is free or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign din.op   = aesri_pkg::opcode_t'(s_axis_tdata[2:0]);
    assign din.data = {s_axis_tdata[130:67], s_axis_tdata[66:3]};
    assign din.key  = {s_axis_tdata[258:195], s_axis_tdata[194:131]};
    assign din.rcon = s_axis_tdata[266:259];

    aesri_sub u_sub (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(s_axis_tvalid),
        .din(din), .vout(v1), .dout(s1)
    );

    aesri_mix u_mix (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(v1),
        .din(s1), .vout(v2), .dout(s2)
    );

    aesri_fin u_fin (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(v2),
        .din(s2), .vout(m_axis_tvalid), .dout(m_axis_tdata)
    );
endmodule

[sv/aesri_chk.sv]
// Port-level checks for the round instruction unit
module aesri_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // Input side follows output backpressure
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // Free output slot always takes input
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled with empty output");
endmodule

bind aes_round_instruction_unit aesri_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
